FILE: design/dsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg: shared types and constants for the sexagenary day converter
// Stage payload structs, calendar tables and the result layout.
// ----------------------------------------------------------------------------
package dsd_pkg;

   localparam int YearW    = 14;
   localparam int MonthW   = 4;
   localparam int DayW     = 5;
   localparam int OrdinalW = 22;   // days from 0001-01-01, up to 3652058
   localparam int OffsetW  = 23;
   localparam int CycleW   = 6;
   localparam int StemW    = 4;
   localparam int BranchW  = 4;
   localparam int ElemW    = 3;

   localparam logic [YearW-1:0]           MaxYear      = 14'd9999;
   localparam logic [MonthW-1:0]          February     = 4'd2;
   localparam logic [MonthW-1:0]          December     = 4'd12;
   localparam logic signed [OffsetW-1:0]  EpochOrdinal = 23'sd730119;
   // (54 - 730119) mod 60, so the cycle index is (ordinal + bias) mod 60
   localparam logic [OrdinalW-1:0]        CycleBias    = 22'd15;

   typedef struct packed {
      logic                ok;
      logic [OrdinalW-1:0] ordinal;
   } dsd_count_type;

   typedef struct packed {
      logic                       ok;
      logic signed [OffsetW-1:0]  offset;
      logic [CycleW-1:0]          cycle;
   } dsd_phase_type;

   typedef struct packed {
      logic                      valid_res;
      logic signed [OffsetW-1:0] day_offset;
      logic [CycleW-1:0]         cycle_index;
      logic [StemW-1:0]          stem_index;
      logic [BranchW-1:0]        branch_index;
      logic [ElemW-1:0]          branch_element;
      logic [ElemW-1:0]          favoured_element;
      logic [ElemW-1:0]          neutral_element;
      logic [ElemW-1:0]          unfavoured_element;
   } dsd_result_type;

   // days before the first of a month in a common year
   function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // length of a month in a common year
   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
      logic [DayW-1:0] r;
      case (m)
         4'd2:                      r = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:        r = 5'd31;
         default:                   r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/date_to_sexagenary_day.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_to_sexagenary_day: Gregorian date to sexagenary day cycle
// Checks a date and gives its day offset, cycle index, stem, branch and
// element indices, one date per clock while results are taken.
// ----------------------------------------------------------------------------
//  channel  ports      direction  payload
//  req      req_t*     in         tdata: year, month, day_of_month
//  rsp      rsp_t*     out        tuser: valid_res; tdata: offset, indices
//
//  One date per cycle sustained while results are taken; the four register
//  stages are input, day count, cycle residue and result.
//  Reset clears the stage valid bits only.
//  A stalled result holds its stage; empty stages upstream keep filling.
// ----------------------------------------------------------------------------
module date_to_sexagenary_day (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // year[13:0], month[17:14], day_of_month[22:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // day_offset[22:0], cycle_index[28:23],
                                    // stem_index[32:29], branch_index[36:33],
                                    // branch_element[39:37], favoured_element[42:40],
                                    // neutral_element[45:43], unfavoured_element[48:46]
   output logic        rsp_tuser    // valid_res[0]
);

   logic                     v0_ff, v1_ff, v2_ff, v3_ff;
   logic                     v0_in, v1_in, v2_in, v3_in;
   logic                     en0, en1, en2, en3;
   logic [22:0]              date0_ff;
   dsd_pkg::dsd_count_type   count_in, count_ff;
   dsd_pkg::dsd_phase_type   phase_in, phase_ff;
   dsd_pkg::dsd_result_type  res_in, res_ff;

   // a stage advances when it is empty or the one after it advances
   assign en3 = !v3_ff || rsp_tready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign en0 = !v0_ff || en1;

   assign req_tready = en0;

   assign v0_in = en0 ? req_tvalid : v0_ff;
   assign v1_in = en1 ? v0_ff      : v1_ff;
   assign v2_in = en2 ? v1_ff      : v2_ff;
   assign v3_in = en3 ? v2_ff      : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   dsd_day_count u_day_count (
      .year         (date0_ff[13:0]),
      .month        (date0_ff[17:14]),
      .day_of_month (date0_ff[22:18]),
      .count        (count_in)
   );

   dsd_cycle_mod u_cycle_mod (
      .count (count_ff),
      .phase (phase_in)
   );

   dsd_cycle_decode u_cycle_decode (
      .phase (phase_ff),
      .res   (res_in)
   );

   always_ff @(posedge clock) begin
      if (en0) begin
         date0_ff <= req_tdata[22:0];
      end
      if (en1) begin
         count_ff <= count_in;
      end
      if (en2) begin
         phase_ff <= phase_in;
      end
      if (en3) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tuser  = res_ff.valid_res;
   assign rsp_tdata  = {7'd0,
                        res_ff.unfavoured_element,
                        res_ff.neutral_element,
                        res_ff.favoured_element,
                        res_ff.branch_element,
                        res_ff.branch_index,
                        res_ff.stem_index,
                        res_ff.cycle_index,
                        res_ff.day_offset};

   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 56'd0)
      else $error("rejected date carries nonzero fields");

   a_cycle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[28:23] < 6'd60)
      else $error("cycle index out of range");

   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result stage");

   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(v3_ff) |-> $past(v2_ff))
      else $error("result appeared without a beat in the residue stage");

endmodule

FILE: design/dsd_day_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_day_count: date check and closed-form day count
// Validates the date and gives the ordinal day number from 0001-01-01.
// ----------------------------------------------------------------------------
module dsd_day_count (
   input  logic [dsd_pkg::YearW-1:0]  year,
   input  logic [dsd_pkg::MonthW-1:0] month,
   input  logic [dsd_pkg::DayW-1:0]   day_of_month,
   output dsd_pkg::dsd_count_type     count
);

   logic [13:0] prev_year;
   logic [11:0] quads;
   logic [23:0] cent_prod;
   logic [7:0]  cents;
   logic [11:0] quad_rem;
   logic [5:0]  quad_cents;
   logic        leap;
   logic [4:0]  mlen;
   logic        year_ok;
   logic        month_ok;
   logic        day_ok;
   logic [21:0] ordinal;

   assign prev_year  = year - 14'd1;
   assign quads      = prev_year[13:2];
   // quads / 25 by reciprocal, exact for quads below 2500
   assign cent_prod  = {12'd0, quads} * 24'd2622;
   assign cents      = cent_prod[23:16];
   assign quad_rem   = quads - ({4'd0, cents} * 12'd25);
   assign quad_cents = cents[7:2];

   // year divisible by 100 shows as a quad remainder of 24; by 400 as cents = 3 mod 4
   assign leap = (year[1:0] == 2'd0) && ((quad_rem != 12'd24) || (cents[1:0] == 2'b11));

   assign mlen     = dsd_pkg::month_len(month)
                   + {4'd0, (month == dsd_pkg::February) && leap};
   assign year_ok  = (year != 14'd0) && (year <= dsd_pkg::MaxYear);
   assign month_ok = (month != 4'd0) && (month <= dsd_pkg::December);
   assign day_ok   = (day_of_month != 5'd0) && (day_of_month <= mlen);

   assign ordinal = ({8'd0, prev_year} * 22'd365)
                  + {10'd0, quads}
                  - {14'd0, cents}
                  + {16'd0, quad_cents}
                  + {13'd0, dsd_pkg::days_before(month)}
                  + {21'd0, (month > dsd_pkg::February) && leap}
                  + {17'd0, day_of_month}
                  - 22'd1;

   assign count.ok      = year_ok && month_ok && day_ok;
   assign count.ordinal = ordinal;

endmodule

FILE: design/dsd_cycle_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_cycle_mod: signed offset and sexagenary residue
// Gives the offset from 2000-01-01 and the day's place in the 60-day cycle.
// ----------------------------------------------------------------------------
module dsd_cycle_mod (
   input  dsd_pkg::dsd_count_type count,
   output dsd_pkg::dsd_phase_type phase
);

   logic [21:0] biased;
   logic [19:0] biased_q4;
   logic [40:0] quot_prod;
   logic [15:0] quot;
   logic [21:0] rem_raw;
   logic [21:0] rem_fix;

   assign biased    = count.ordinal + dsd_pkg::CycleBias;
   // floor(x/60) = floor(floor(x/4)/15); 1118482 / 2^24 covers the 20-bit range
   assign biased_q4 = biased[21:2];
   assign quot_prod = {21'd0, biased_q4} * 41'd1118482;
   assign quot      = quot_prod[39:24];
   assign rem_raw   = biased - ({6'd0, quot} * 22'd60);
   assign rem_fix   = (rem_raw >= 22'd60) ? (rem_raw - 22'd60) : rem_raw;

   assign phase.ok     = count.ok;
   assign phase.offset = $signed({1'b0, count.ordinal}) - dsd_pkg::EpochOrdinal;
   assign phase.cycle  = rem_fix[5:0];

endmodule

FILE: design/dsd_cycle_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_cycle_decode: stem, branch and element decode
// Splits the cycle index into stem and branch and derives the elements.
// ----------------------------------------------------------------------------
module dsd_cycle_decode (
   input  dsd_pkg::dsd_phase_type  phase,
   output dsd_pkg::dsd_result_type res
);

   logic [5:0] stem_r;
   logic [5:0] branch_r;
   logic [2:0] elem;
   logic [2:0] fav;
   logic [2:0] unfav;

   // element of each earthly branch
   function automatic logic [2:0] branch_elem(input logic [3:0] b);
      logic [2:0] r;
      case (b)
         4'd0, 4'd11:              r = 3'd4;
         4'd1, 4'd4, 4'd7, 4'd10:  r = 3'd2;
         4'd2, 4'd3:               r = 3'd0;
         4'd5, 4'd6:               r = 3'd1;
         4'd8, 4'd9:               r = 3'd3;
         default:                  r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] elem_add(input logic [2:0] e, input logic [2:0] k);
      logic [3:0] s;
      s = {1'b0, e} + {1'b0, k};
      return (s >= 4'd5) ? 3'(s - 4'd5) : s[2:0];
   endfunction

   // cycle is below 60: three conditional subtracts give each residue
   always_comb begin
      stem_r = phase.cycle;
      if (stem_r >= 6'd40) stem_r = stem_r - 6'd40;
      if (stem_r >= 6'd20) stem_r = stem_r - 6'd20;
      if (stem_r >= 6'd10) stem_r = stem_r - 6'd10;
      branch_r = phase.cycle;
      if (branch_r >= 6'd48) branch_r = branch_r - 6'd48;
      if (branch_r >= 6'd24) branch_r = branch_r - 6'd24;
      if (branch_r >= 6'd12) branch_r = branch_r - 6'd12;
   end

   assign elem  = branch_elem(branch_r[3:0]);
   assign fav   = elem_add(elem, 3'd1);
   assign unfav = elem_add(elem, 3'd2);

   // zero every field of a rejected date
   always_comb begin
      res = '0;
      if (phase.ok) begin
         res.valid_res          = 1'b1;
         res.day_offset         = phase.offset;
         res.cycle_index        = phase.cycle;
         res.stem_index         = stem_r[3:0];
         res.branch_index       = branch_r[3:0];
         res.branch_element     = elem;
         res.favoured_element   = fav;
         res.neutral_element    = elem;
         res.unfavoured_element = unfav;
      end
   end

endmodule

FILE: test/date_to_sexagenary_day_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_to_sexagenary_day_test: self-checking bench for the date converter
// Streams directed edge dates, then random dates (mostly well formed, some
// raw noise) under four idle/stall patterns. Every result beat is checked
// field by field against a calendar computed in the bench.
// ----------------------------------------------------------------------------
module date_to_sexagenary_day_test;

   localparam int BASE_ORDINAL   = 730119;   // days from 0001-01-01 to 2000-01-01
   localparam int CYCLE_AT_BASE  = 54;       // 2000-01-01 is wu-wu
   localparam int CYCLE_LEN      = 60;
   localparam int ELEMENT_COUNT  = 5;
   localparam int RANDOM_PER_PHASE = 475;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 12;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // year[13:0], month[17:14], day_of_month[22:18]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // day_offset, cycle, stem, branch, four elements
   logic        rsp_tuser;        // valid_res[0]

   logic [23:0]             pending_dates[$];
   dsd_pkg::dsd_result_type expected_days[$];

   int  send_idle_pct  = 0;
   int  rsp_stall_pct  = 0;
   logic req_took      = 1'b0;
   int  dates_queued   = 0;
   int  dates_taken    = 0;
   int  days_checked   = 0;
   int  days_valid     = 0;
   int  days_before_base = 0;
   int  mismatches     = 0;
   int  quiet_cycles   = 0;

   date_to_sexagenary_day i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic bit is_leap(input int yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic int days_in_month(input int yr, input int mo);
      int len;
      case (mo)
         2:             len = is_leap(yr) ? 29 : 28;
         4, 6, 9, 11:   len = 30;
         default:       len = 31;
      endcase
      return len;
   endfunction

   function automatic int days_ahead_of(input int mo);
      int total;
      total = 0;
      for (int k = 1; k < mo; k++) begin
         total += (k == 2) ? 28 : days_in_month(1, k);
      end
      return total;
   endfunction

   // wood 0, fire 1, earth 2, metal 3, water 4
   function automatic int element_of_branch(input int branch);
      int elem;
      case (branch)
         0, 11:           elem = 4;
         2, 3:            elem = 0;
         5, 6:            elem = 1;
         8, 9:            elem = 3;
         default:         elem = 2;
      endcase
      return elem;
   endfunction

   function automatic dsd_pkg::dsd_result_type predict_day_cycle(input logic [23:0] beat);
      dsd_pkg::dsd_result_type r;
      int yr, mo, dy, yp, ordinal, offset, cyc, elem;
      r  = '0;
      yr = beat[13:0];
      mo = beat[17:14];
      dy = beat[22:18];
      if (yr < 1 || yr > 9999 || mo < 1 || mo > 12) return r;
      if (dy < 1 || dy > days_in_month(yr, mo)) return r;
      yp      = yr - 1;
      ordinal = 365 * yp + yp / 4 - yp / 100 + yp / 400 + days_ahead_of(mo)
              + ((mo > 2 && is_leap(yr)) ? 1 : 0) + dy - 1;
      offset  = ordinal - BASE_ORDINAL;
      cyc     = (CYCLE_AT_BASE + offset) % CYCLE_LEN;
      if (cyc < 0) cyc += CYCLE_LEN;
      elem    = element_of_branch(cyc % 12);
      r.valid_res          = 1'b1;
      r.day_offset         = offset[dsd_pkg::OffsetW-1:0];
      r.cycle_index        = cyc[dsd_pkg::CycleW-1:0];
      r.stem_index         = 4'(cyc % 10);
      r.branch_index       = 4'(cyc % 12);
      r.branch_element     = elem[dsd_pkg::ElemW-1:0];
      r.favoured_element   = 3'((elem + 1) % ELEMENT_COUNT);
      r.neutral_element    = elem[dsd_pkg::ElemW-1:0];
      r.unfavoured_element = 3'((elem + 2) % ELEMENT_COUNT);
      return r;
   endfunction

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   task automatic queue_date(input int yr, input int mo, input int dy);
      pending_dates.push_back({1'b0, 5'(dy), 4'(mo), 14'(yr)});
      dates_queued++;
   endtask

   // driver: hold a beat until taken, then maybe idle
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && !req_took) begin
            req_tvalid <= 1'b1;
         end else if (pending_dates.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= pending_dates.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor: check results, record accepted dates, watch for a hang
   always @(posedge clock) begin : monitor
      dsd_pkg::dsd_result_type seen, want;
      if (reset) begin
         req_took     <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            seen.valid_res          = rsp_tuser;
            seen.day_offset         = rsp_tdata[22:0];
            seen.cycle_index        = rsp_tdata[28:23];
            seen.stem_index         = rsp_tdata[32:29];
            seen.branch_index       = rsp_tdata[36:33];
            seen.branch_element     = rsp_tdata[39:37];
            seen.favoured_element   = rsp_tdata[42:40];
            seen.neutral_element    = rsp_tdata[45:43];
            seen.unfavoured_element = rsp_tdata[48:46];
            days_checked++;
            if (expected_days.size() == 0) begin
               $error("result beat with no date outstanding");
               mismatches++;
            end else begin
               want = expected_days.pop_front();
               if (want.valid_res) days_valid++;
               if (want.day_offset < 0) days_before_base++;
               compare_field("valid_res", want.valid_res, seen.valid_res);
               compare_field("day_offset", want.day_offset, seen.day_offset);
               compare_field("cycle_index", want.cycle_index, seen.cycle_index);
               compare_field("stem_index", want.stem_index, seen.stem_index);
               compare_field("branch_index", want.branch_index, seen.branch_index);
               compare_field("branch_element", want.branch_element,
                             seen.branch_element);
               compare_field("favoured_element", want.favoured_element,
                             seen.favoured_element);
               compare_field("neutral_element", want.neutral_element,
                             seen.neutral_element);
               compare_field("unfavoured_element", want.unfavoured_element,
                             seen.unfavoured_element);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_days.push_back(predict_day_cycle(req_tdata));
            dates_taken++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int yr, mo, dy, pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edge dates: epoch, range ends, leap rules, bad fields
      queue_date(2000, 1, 1);
      queue_date(1999, 12, 31);
      queue_date(1, 1, 1);
      queue_date(9999, 12, 31);
      queue_date(2000, 2, 29);
      queue_date(1900, 2, 29);
      queue_date(1900, 2, 28);
      queue_date(2024, 2, 29);
      queue_date(2023, 2, 29);
      queue_date(2400, 2, 29);
      queue_date(2000, 3, 1);
      queue_date(0, 1, 1);
      queue_date(10000, 1, 1);
      queue_date(16383, 15, 31);
      queue_date(0, 0, 0);
      queue_date(2021, 0, 5);
      queue_date(2021, 13, 5);
      queue_date(2021, 15, 10);
      queue_date(2021, 4, 31);
      queue_date(2021, 4, 30);
      queue_date(2021, 1, 0);
      queue_date(2021, 12, 31);
      queue_date(1582, 10, 10);
      queue_date(8191, 7, 16);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 56; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 56; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
               // raw noise across every bit of every field
               queue_date($urandom_range(16383), $urandom_range(15), $urandom_range(31));
            end else begin
               if (pick < 25) begin
                  case ($urandom_range(4))
                     0:       yr = 1;
                     1:       yr = 9999;
                     2:       yr = 1999;
                     3:       yr = 2000;
                     default: yr = 100 * $urandom_range(1, 99);
                  endcase
               end else begin
                  yr = $urandom_range(1, 9999);
               end
               mo = $urandom_range(1, 12);
               dy = $urandom_range(1, days_in_month(yr, mo));
               queue_date(yr, mo, dy);
            end
         end
         wait (dates_taken == dates_queued);
      end

      wait (days_checked == dates_taken);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_days.size() != 0) begin
         $error("%0d expected results never arrived", expected_days.size());
         mismatches++;
      end
      $display("checked %0d result beats: %0d valid dates, %0d rejected, %0d before the base day",
               days_checked, days_valid, days_checked - days_valid, days_before_base);
      $display("four idle/stall patterns run, %0d field mismatches", mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
